/* rtl/core/ddaw_pkg.sv */
// Shared types, constants and helper functions of the differential drive arc block.
`default_nettype none
package ddaw_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumBits  = WordBits + FracBits;
  localparam int unsigned DivCells = NumBits;
  localparam int unsigned Lanes    = 6;
  localparam int unsigned AddrBits = 4;

  localparam logic [1:0] RegWheelBase = 2'd0;
  localparam logic [1:0] RegStepDist  = 2'd1;
  localparam logic [1:0] RegStraight  = 2'd2;
  localparam logic [1:0] RegPointTurn = 2'd3;

  localparam logic signed [WordBits+1:0] OneQ = (WordBits + 2)'(1) <<< FracBits;

  typedef enum logic [1:0] {
    ModeStraight,
    ModePoint,
    ModeArc,
    ModeFail
  } mode_e;

  typedef struct packed {
    logic signed [31:0] radius;
    logic signed [31:0] length;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic               brake;
    logic               blocking;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               left_forward;
    logic               right_forward;
    logic signed [31:0] left_steps;
    logic signed [31:0] right_steps;
    logic signed [31:0] left_rate;
    logic signed [31:0] right_rate;
    logic signed [31:0] left_ramp;
    logic signed [31:0] right_ramp;
    logic               brake_out;
    logic               blocking_out;
  } res_t;

  typedef struct packed {
    logic [30:0] track_width;
    logic [30:0] step_distance;
    logic [31:0] straight_code;
    logic [31:0] point_turn_code;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        rem;
    logic [NumBits-1:0] num;
    logic [31:0]        quo;
    logic               ovf;
    logic [31:0]        dvs;
    logic               neg;
    logic               zero;
  } div_lane_t;

  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? 32'(~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] div_result(div_lane_t l);
    logic big;
    big = l.ovf | l.quo[31];
    if (l.zero) begin
      return 32'd0;
    end else if (!l.neg) begin
      return big ? 32'h7FFF_FFFF : l.quo;
    end else begin
      return big ? 32'h8000_0000 : 32'(~l.quo + 32'd1);
    end
  endfunction

  function automatic logic [31:0] sat34(logic signed [WordBits+1:0] v);
    if (v > $signed((WordBits + 2)'(32'h7FFF_FFFF))) begin
      return 32'h7FFF_FFFF;
    end else if (v < -$signed((WordBits + 2)'(33'h0_8000_0000))) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ddaw_div_cell.sv */
// One restoring division step with its pipeline register.
`default_nettype none
module ddaw_div_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  ddaw_pkg::div_lane_t lane_i,
  output ddaw_pkg::div_lane_t lane_o
);
  import ddaw_pkg::*;

  logic [32:0] rem2;
  logic [32:0] diff;
  logic        ge;
  div_lane_t   lane_d;
  div_lane_t   lane_q;

  always_comb begin
    rem2 = {lane_i.rem, lane_i.num[NumBits-1]};
    ge   = rem2 >= {1'b0, lane_i.dvs};
    diff = rem2 - {1'b0, lane_i.dvs};
    lane_d      = lane_i;
    lane_d.rem  = ge ? diff[31:0] : rem2[31:0];
    lane_d.num  = {lane_i.num[NumBits-2:0], 1'b0};
    lane_d.quo  = {lane_i.quo[30:0], ge};
    lane_d.ovf  = lane_i.ovf | lane_i.quo[31];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

/* rtl/core/ddaw_apb_regs.sv */
// Configuration registers behind the APB-style port.
`default_nettype none
module ddaw_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddaw_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ddaw_pkg::cfg_t                cfg_o
);
  import ddaw_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_width     <= 31'd0;
      cfg_q.step_distance   <= 31'h0001_0000;
      cfg_q.straight_code   <= 32'h7FFF_FFFF;
      cfg_q.point_turn_code <= 32'd0;
    end else if (wr) begin
      unique case (idx)
        RegWheelBase: cfg_q.track_width     <= pwdata[30:0];
        RegStepDist:  cfg_q.step_distance   <= pwdata[30:0];
        RegStraight:  cfg_q.straight_code   <= pwdata;
        RegPointTurn: cfg_q.point_turn_code <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegWheelBase: prdata = {1'b0, cfg_q.track_width};
      RegStepDist:  prdata = {1'b0, cfg_q.step_distance};
      RegStraight:  prdata = cfg_q.straight_code;
      RegPointTurn: prdata = cfg_q.point_turn_code;
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* rtl/core/diff_drive_arc_wheel_commands.sv */
// Differential drive arc block: one arc request in, left and right wheel step commands out.
// Takes one request per cycle while the output is not stalled; each request passes through
// a chain of 48 restoring-division cells (radius ratio), the factor and multiply registers,
// six parallel chains of 48 cells (per-wheel division by step distance) and an output register.
// A stalled output stalls the whole pipeline.
`default_nettype none
module diff_drive_arc_wheel_commands (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ddaw_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ddaw_pkg::res_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddaw_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ddaw_pkg::*;

  typedef struct packed {
    mode_e       mode;
    logic        fwd;
    logic        brake;
    logic        blocking;
    logic [31:0] length;
    logic [31:0] speed;
    logic [31:0] accel;
  } side_t;

  typedef struct packed {
    mode_e mode;
    logic  fwd;
    logic  brake;
    logic  blocking;
  } tail_t;

  cfg_t cfg;
  logic adv;
  logic acc;

  ddaw_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  logic out_vld_q;
  res_t out_q;

  assign adv        = ~out_vld_q | out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i & adv;

  side_t     ent_side;
  div_lane_t rat_lane [DivCells+1];

  always_comb begin
    ent_side.fwd      = ~in_data_i.length[31] & (in_data_i.length != 32'd0);
    ent_side.brake    = in_data_i.brake;
    ent_side.blocking = in_data_i.blocking;
    ent_side.length   = in_data_i.length;
    ent_side.speed    = in_data_i.speed;
    ent_side.accel    = in_data_i.accel;
    if (in_data_i.radius == cfg.straight_code) begin
      ent_side.mode = ModeStraight;
    end else if (in_data_i.radius == cfg.point_turn_code) begin
      ent_side.mode = ModePoint;
    end else if (in_data_i.radius == 32'd0) begin
      ent_side.mode = ModeFail;
    end else begin
      ent_side.mode = ModeArc;
    end
    rat_lane[0].rem  = 32'd0;
    rat_lane[0].num  = {1'b0, cfg.track_width, FracBits'(0)};
    rat_lane[0].quo  = 32'd0;
    rat_lane[0].ovf  = 1'b0;
    rat_lane[0].dvs  = mag32(in_data_i.radius);
    rat_lane[0].neg  = in_data_i.radius[31];
    rat_lane[0].zero = cfg.track_width == 31'd0;
  end

  logic [DivCells-1:0] rat_vld_q;
  side_t               rat_side_q [DivCells];

  for (genvar i = 0; i < DivCells; i++) begin : g_rat
    ddaw_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .lane_i(rat_lane[i]),
      .lane_o(rat_lane[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rat_vld_q <= '0;
    end else if (adv) begin
      rat_vld_q <= {rat_vld_q[DivCells-2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rat_side_q[0] <= ent_side;
      for (int i = 1; i < DivCells; i++) begin
        rat_side_q[i] <= rat_side_q[i-1];
      end
    end
  end

  logic                         f_vld_q;
  side_t                        f_side_q;
  logic [31:0]                  fl_q;
  logic [31:0]                  fr_q;
  logic [31:0]                  ratio;
  logic signed [WordBits+1:0]   ratio_x;

  assign ratio   = div_result(rat_lane[DivCells]);
  assign ratio_x = (WordBits + 2)'($signed(ratio));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= rat_vld_q[DivCells-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_side_q <= rat_side_q[DivCells-1];
      fl_q     <= sat34(OneQ - ratio_x);
      fr_q     <= sat34(OneQ + ratio_x);
    end
  end

  logic        m_vld_q;
  side_t       m_side_q;
  logic [46:0] m_prod_q [Lanes];
  logic        m_neg_q  [Lanes];
  logic [31:0] f_x      [3];

  assign f_x[0] = f_side_q.length;
  assign f_x[1] = f_side_q.speed;
  assign f_x[2] = f_side_q.accel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= f_vld_q;
    end
  end

  div_lane_t whl_lane [Lanes][DivCells+1];

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    localparam int unsigned Src = k / 2;
    logic [31:0] fac;
    logic [63:0] prod;
    logic [31:0] sx;
    logic [31:0] mv;

    assign fac  = ((k % 2) == 1) ? fr_q : fl_q;
    assign prod = 64'(mag32(f_x[Src])) * 64'(mag32(fac));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        m_prod_q[k] <= prod[62:16];
        m_neg_q[k]  <= f_x[Src][31] ^ fac[31];
      end
    end

    assign sx = (Src == 0) ? m_side_q.length : (Src == 1) ? m_side_q.speed : m_side_q.accel;

    always_comb begin
      if (m_side_q.mode == ModeArc) begin
        if (m_neg_q[k]) begin
          mv = (m_prod_q[k] > 47'h0_8000_0000) ? 32'h8000_0000 : m_prod_q[k][31:0];
        end else begin
          mv = (m_prod_q[k] > 47'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m_prod_q[k][31:0];
        end
      end else begin
        mv = mag32(sx);
      end
      whl_lane[k][0].rem  = 32'd0;
      whl_lane[k][0].num  = {mv, FracBits'(0)};
      whl_lane[k][0].quo  = 32'd0;
      whl_lane[k][0].ovf  = 1'b0;
      whl_lane[k][0].dvs  = {1'b0, cfg.step_distance};
      whl_lane[k][0].neg  = (m_side_q.mode == ModeArc) & m_neg_q[k];
      whl_lane[k][0].zero = mv == 32'd0;
    end

    for (genvar i = 0; i < DivCells; i++) begin : g_cell
      ddaw_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .lane_i(whl_lane[k][i]),
        .lane_o(whl_lane[k][i+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_side_q <= f_side_q;
    end
  end

  logic [DivCells-1:0] whl_vld_q;
  tail_t               whl_side_q [DivCells];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whl_vld_q <= '0;
    end else if (adv) begin
      whl_vld_q <= {whl_vld_q[DivCells-2:0], m_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      whl_side_q[0] <= '{mode: m_side_q.mode, fwd: m_side_q.fwd,
                         brake: m_side_q.brake, blocking: m_side_q.blocking};
      for (int i = 1; i < DivCells; i++) begin
        whl_side_q[i] <= whl_side_q[i-1];
      end
    end
  end

  res_t  res_d;
  tail_t tl;

  assign tl = whl_side_q[DivCells-1];

  always_comb begin
    if (tl.mode == ModeFail) begin
      res_d        = '0;
      res_d.status = 1'b1;
    end else begin
      res_d.status        = 1'b0;
      res_d.left_forward  = (tl.mode == ModePoint) ? ~tl.fwd : tl.fwd;
      res_d.right_forward = tl.fwd;
      res_d.left_steps    = div_result(whl_lane[0][DivCells]);
      res_d.right_steps   = div_result(whl_lane[1][DivCells]);
      res_d.left_rate     = div_result(whl_lane[2][DivCells]);
      res_d.right_rate    = div_result(whl_lane[3][DivCells]);
      res_d.left_ramp     = div_result(whl_lane[4][DivCells]);
      res_d.right_ramp    = div_result(whl_lane[5][DivCells]);
      res_d.brake_out     = tl.brake;
      res_d.blocking_out  = tl.blocking;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= whl_vld_q[DivCells-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for the differential drive arc block: directed and random requests checked by a scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddaw_pkg::*;

  localparam longint SMax = 64'sh7FFF_FFFF;
  localparam longint SMin = -64'sh8000_0000;
  localparam longint OneQ64 = 64'sd65536;
  localparam int Latency = 99;
  localparam longint Limit = 2000000;

  class wheel_cmd_board;
    res_t pending[$];
    int errors;
    logic [30:0] base_q, step_q;
    logic signed [31:0] straight_q, point_q;

    function new();
      errors = 0;
      base_q = 0;
      step_q = 31'd65536;
      straight_q = 32'sh7FFF_FFFF;
      point_q = 0;
    endfunction

    function longint sat_mag(bit neg, logic [63:0] m);
      if (!neg) return (m > 64'h7FFF_FFFF) ? SMax : longint'(m);
      if (m > 64'h8000_0000) return SMin;
      return -longint'(m);
    endfunction

    function logic [63:0] absv(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function longint qdiv(bit neg, logic [63:0] m, logic [63:0] d);
      if (m == 0) return 0;
      if (d == 0 || m > (64'hFFFF_FFFF_FFFF_FFFF >> 16)) return sat_mag(neg, '1);
      return sat_mag(neg, (m << 16) / d);
    endfunction

    function longint qmul(longint a, longint b);
      logic [127:0] p;
      if (a == 0 || b == 0) return 0;
      p = 128'(absv(a)) * 128'(absv(b));
      if (p[127:64] != 0) return sat_mag((a < 0) != (b < 0), '1);
      return sat_mag((a < 0) != (b < 0), p[63:0] >> 16);
    endfunction

    function longint clamp(longint x);
      return x > SMax ? SMax : (x < SMin ? SMin : x);
    endfunction

    function logic [31:0] wheel(longint x, longint f);
      longint v;
      v = qmul(x, f);
      return 32'(qdiv(v < 0, absv(v), 64'(step_q)));
    endfunction

    function void note_request(req_t r);
      res_t e;
      longint rad, ratio, fl, fr;
      bit fwd;
      e = '0;
      rad = r.radius;
      fwd = r.length > 0;
      if (r.radius == straight_q || r.radius == point_q) begin
        e.left_steps = 32'(qdiv(0, absv(r.length), 64'(step_q)));
        e.left_rate = 32'(qdiv(0, absv(r.speed), 64'(step_q)));
        e.left_ramp = 32'(qdiv(0, absv(r.accel), 64'(step_q)));
        e.right_steps = e.left_steps;
        e.right_rate = e.left_rate;
        e.right_ramp = e.left_ramp;
        e.left_forward = (r.radius == straight_q) ? fwd : !fwd;
        e.right_forward = fwd;
      end else if (rad == 0) begin
        e.status = 1'b1;
        pending.push_back(e);
        return;
      end else begin
        ratio = qdiv(rad < 0, 64'(base_q), absv(rad));
        fl = clamp(OneQ64 - ratio);
        fr = clamp(OneQ64 + ratio);
        e.left_steps = wheel(r.length, fl);
        e.right_steps = wheel(r.length, fr);
        e.left_rate = wheel(r.speed, fl);
        e.right_rate = wheel(r.speed, fr);
        e.left_ramp = wheel(r.accel, fl);
        e.right_ramp = wheel(r.accel, fr);
        e.left_forward = fwd;
        e.right_forward = fwd;
      end
      e.brake_out = r.brake;
      e.blocking_out = r.blocking;
      pending.push_back(e);
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        $display("%0t: mismatch expected %h actual %h", $time, e, a);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  req_t in_data_i;
  res_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [AddrBits-1:0] paddr;
  logic [31:0] pwdata, prdata;
  wheel_cmd_board board;
  longint cycles;
  bit calm;

  diff_drive_arc_wheel_commands u_dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > Limit) begin
        $display("diff_drive_arc_wheel_commands test failed");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 7);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= AddrBits'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegWheelBase: board.base_q = val[30:0];
      RegStepDist: board.step_q = val[30:0];
      RegStraight: board.straight_q = val;
      default: board.point_q = val;
    endcase
  endtask

  task automatic send(req_t r);
    if (!calm) begin
      while ($urandom_range(99) < 7) begin
        in_valid_i <= 0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(1 << 20);
      4: return -$urandom_range(1 << 20);
      5: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req(int kind);
    req_t r;
    r.length = pick(); r.speed = pick(); r.accel = pick();
    r.brake = 1'($urandom); r.blocking = 1'($urandom);
    case (kind)
      0: r.radius = board.straight_q;
      1: r.radius = board.point_q;
      2: r.radius = 0;
      default: r.radius = pick();
    endcase
    return r;
  endfunction

  function automatic req_t mk(logic [31:0] rad, logic [31:0] len, logic [31:0] spd,
                              logic [31:0] acc, bit b, bit k);
    req_t r;
    r.radius = rad; r.length = len; r.speed = spd; r.accel = acc;
    r.brake = b; r.blocking = k;
    return r;
  endfunction

  initial begin
    logic [31:0] bases[4], steps[4], codes[4];
    board = new();
    calm = 0;
    rst_ni = 0; in_valid_i = 0; in_data_i = '0; out_ready_i = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // reset settings: straight at max code, point turn at zero
    send(mk(32'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1, 0));
    send(mk(32'h0, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1));
    send(mk(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1, 1));
    drain();
    write_reg(RegWheelBase, 32'h0002_0000);
    write_reg(RegStepDist, 32'h0000_8000);
    write_reg(RegStraight, 32'h7FFF_FFFF);
    write_reg(RegPointTurn, 32'h8000_0000);
    send(mk(32'h0, 32'h1234, 32'h1, 32'h2, 1, 1));
    send(mk(32'h8000_0000, 32'h0001_0000, 32'h1, 32'h2, 0, 0));
    send(mk(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0));
    send(mk(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 1));
    send(mk(32'h0000_0001, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 1));
    send(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 0, 0));
    drain();
    write_reg(RegStraight, 32'h0000_5000);
    write_reg(RegPointTurn, 32'h0000_5000);
    send(mk(32'h0000_5000, 32'h0003_0000, 32'h1, 32'h8000_0000, 1, 0));
    send(mk(32'h0, 32'h0003_0000, 32'h1, 32'h1, 1, 0));
    drain();
    bases = '{32'h0, 32'h7FFF_FFFF, 32'h0001_8000, 32'h0000_0100};
    steps = '{32'h1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_4000};
    codes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0003_0000};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegWheelBase, (ph < 4) ? bases[ph] : $urandom);
      write_reg(RegStepDist, (ph < 4) ? steps[ph] : $urandom_range(32'h7FFF_FFFF, 1));
      write_reg(RegStraight, codes[ph % 4]);
      write_reg(RegPointTurn, codes[(ph + 1) % 4] ^ (ph > 3 ? $urandom : 0));
      calm = (ph == 5);
      for (int n = 0; n < 210; n++) send(rand_req($urandom_range(9)));
      calm = 0;
      drain();
    end
    if (board.errors == 0) begin
      $display("diff_drive_arc_wheel_commands test passed");
    end else begin
      $display("diff_drive_arc_wheel_commands test failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/ddaw_pkg.sv
rtl/core/ddaw_div_cell.sv
rtl/core/ddaw_apb_regs.sv
rtl/core/diff_drive_arc_wheel_commands.sv
bench/tb.sv
